// ===== sv/fvt_pkg.sv =====
// fvt_pkg: shared constants and types for the fixed-point vertex transform.
// Used by fvt_div and fixed_point_vertex_transform.
package fvt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAT_ENTRIES   = 16;

  // tuser bit 0 on the input side
  localparam logic KIND_MATRIX = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_HALF_W = 2'd0;
  localparam logic [1:0] CFG_HALF_H = 2'd1;

  // per-vertex data carried alongside the reciprocal pipeline
  typedef struct packed {
    logic signed [63:0] clip_x;
    logic signed [63:0] clip_y;
    logic signed [63:0] clip_z;
    logic [47:0]        clip_w;
    logic               visible;
    logic [31:0]        tex_u;
    logic [31:0]        tex_v;
    logic [31:0]        colour;
  } side_t;

endpackage

// ===== sv/fixed_point_vertex_transform.sv =====
// fixed_point_vertex_transform: MVP transform, reciprocal w, viewport map.
// Depends on fvt_pkg and fvt_div.
//
// One item is taken per clock while the result side keeps up; matrix writes
// update the stored 4x4 matrix at once and every later vertex sees them.
// A vertex result passes through three stages of matrix multiply and sum,
// one stage per quotient bit of the 2^(2*FRAC_BITS)/w divider, then five
// stages of perspective multiply and viewport mapping; positions are 16.16
// at the default FRAC_BITS. A stalled output holds the whole pipeline.
// Matrix entries and the viewport registers are zero after reset.
module fixed_point_vertex_transform
  import fvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index, entry_value, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_colour
  input  logic [231:0] in_tdata,
  // kind, textured
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // clip_x, clip_y, clip_z, clip_w, visible, inverse_w, screen_x, screen_y,
  // depth_ndc, out_u, out_v, out_colour
  output logic [551:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);

  logic en;
  logic in_xfer;
  logic [3:0]  in_idx;
  logic [31:0] in_ev, in_px, in_py, in_pz, in_u, in_v, in_col;

  assign in_idx = in_tdata[3:0];
  assign in_ev  = in_tdata[35:4];
  assign in_px  = in_tdata[67:36];
  assign in_py  = in_tdata[99:68];
  assign in_pz  = in_tdata[131:100];
  assign in_u   = in_tdata[163:132];
  assign in_v   = in_tdata[195:164];
  assign in_col = in_tdata[227:196];

  logic out_valid_r;
  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign in_xfer    = in_tvalid && en;
  assign out_tvalid = out_valid_r;

  // configuration
  logic [30:0] hw_r, hh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
      hh_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HALF_W) hw_r <= cfg_wdata;
      if (cfg_index == CFG_HALF_H) hh_r <= cfg_wdata;
    end
  end

  // matrix store
  logic [31:0] mat_r [MAT_ENTRIES];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAT_ENTRIES; i++) mat_r[i] <= '0;
    end else if (in_xfer && in_tuser[0] == KIND_MATRIX) begin
      mat_r[in_idx] <= in_ev;
    end
  end

  // stage 1: products
  logic               v1_r;
  logic signed [63:0] p1_r    [4][3];
  logic signed [63:0] bias1_r [4];
  logic [31:0]        u1_r, tv1_r, col1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_xfer && in_tuser[0] == KIND_VERTEX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        p1_r[c][0] <= 64'($signed(in_px) * $signed(mat_r[c]));
        p1_r[c][1] <= 64'($signed(in_py) * $signed(mat_r[4+c]));
        p1_r[c][2] <= 64'($signed(in_pz) * $signed(mat_r[8+c]));
        bias1_r[c] <= 64'($signed(mat_r[12+c])) <<< FRAC_BITS;
      end
      u1_r   <= in_tuser[1] ? in_u : 32'd0;
      tv1_r  <= in_tuser[1] ? in_v : 32'd0;
      col1_r <= in_col;
    end
  end

  // stage 2: pair sums
  logic               v2_r;
  logic signed [63:0] a2_r [4];
  logic signed [63:0] b2_r [4];
  logic [31:0]        u2_r, tv2_r, col2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        a2_r[c] <= p1_r[c][0] + p1_r[c][1];
        b2_r[c] <= p1_r[c][2] + bias1_r[c];
      end
      u2_r   <= u1_r;
      tv2_r  <= tv1_r;
      col2_r <= col1_r;
    end
  end

  // stage 3: final sum, clip coordinates, magnitude of w
  logic               v3_r;
  logic signed [63:0] sum3 [4];
  logic signed [63:0] clip3_r [4];
  logic               vis3_r, neg3_r;
  logic [63:0]        mag3_r;
  logic [31:0]        u3_r, tv3_r, col3_r;
  logic signed [63:0] clip_w3;

  always_comb begin
    for (int c = 0; c < 4; c++) sum3[c] = a2_r[c] + b2_r[c];
  end
  assign clip_w3 = sum3[3] >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) clip3_r[c] <= sum3[c] >>> FRAC_BITS;
      vis3_r <= !sum3[2][63];
      neg3_r <= clip_w3[63];
      mag3_r <= clip_w3[63] ? (64'd0 - clip_w3) : clip_w3;
      u3_r   <= u2_r;
      tv3_r  <= tv2_r;
      col3_r <= col2_r;
    end
  end

  side_t side3;
  assign side3 = '{clip_x: clip3_r[0], clip_y: clip3_r[1], clip_z: clip3_r[2],
                   clip_w: clip3_r[3][47:0], visible: vis3_r,
                   tex_u: u3_r, tex_v: tv3_r, colour: col3_r};

  logic        dv;
  logic [63:0] dinv;
  side_t       dside;

  fvt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_mag    (mag3_r),
    .in_neg    (neg3_r),
    .in_side   (side3),
    .out_valid (dv),
    .out_inv   (dinv),
    .out_side  (dside)
  );

  // stage 4: register reciprocal
  logic        v4_r;
  logic [63:0] inv4_r;
  side_t       side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inv4_r  <= dinv;
      side4_r <= dside;
    end
  end

  // stage 5: partial products of clip x, y, z times inverse w
  logic        v5_r;
  logic [63:0] ll5_r [3];
  logic [31:0] hl5_r [3];
  logic [31:0] lh5_r [3];
  logic [63:0] inv5_r;
  side_t       side5_r;
  logic [63:0] ca [3];

  assign ca[0] = side4_r.clip_x;
  assign ca[1] = side4_r.clip_y;
  assign ca[2] = side4_r.clip_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ll5_r[i] <= 64'(ca[i][31:0] * inv4_r[31:0]);
        hl5_r[i] <= 32'(ca[i][63:32] * inv4_r[31:0]);
        lh5_r[i] <= 32'(ca[i][31:0] * inv4_r[63:32]);
      end
      inv5_r  <= inv4_r;
      side5_r <= side4_r;
    end
  end

  // stage 6: combine and scale to NDC
  logic               v6_r;
  logic signed [63:0] ndc6_r [3];
  logic signed [63:0] prod6  [3];
  logic [63:0]        inv6_r;
  side_t              side6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod6[i] = ll5_r[i] + {hl5_r[i] + lh5_r[i], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) ndc6_r[i] <= prod6[i] >>> FRAC_BITS;
      inv6_r  <= inv5_r;
      side6_r <= side5_r;
    end
  end

  // stage 7: partial products of NDC times viewport halves
  logic        v7_r;
  logic [63:0] xl7_r, yl7_r;
  logic [31:0] xh7_r, yh7_r;
  logic [63:0] depth7_r, inv7_r;
  side_t       side7_r;
  logic [31:0] hw32, hh32;

  assign hw32 = {1'b0, hw_r};
  assign hh32 = {1'b0, hh_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xl7_r    <= 64'(ndc6_r[0][31:0] * hw32);
      xh7_r    <= 32'(ndc6_r[0][63:32] * hw32);
      yl7_r    <= 64'(ndc6_r[1][31:0] * hh32);
      yh7_r    <= 32'(ndc6_r[1][63:32] * hh32);
      depth7_r <= ndc6_r[2];
      inv7_r   <= inv6_r;
      side7_r  <= side6_r;
    end
  end

  // stage 8: viewport offset, output register
  logic signed [63:0] tx8, ty8;
  logic [63:0]        sx_r, sy_r, depth_r, inv_r;
  side_t              side_r;

  assign tx8 = xl7_r + {xh7_r, 32'd0};
  assign ty8 = yl7_r + {yh7_r, 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r    <= {33'd0, hw_r} + 64'(tx8 >>> FRAC_BITS);
      sy_r    <= {33'd0, hh_r} - 64'(ty8 >>> FRAC_BITS);
      depth_r <= depth7_r;
      inv_r   <= inv7_r;
      side_r  <= side7_r;
    end
  end

  assign out_tdata = {7'd0, side_r.colour, side_r.tex_v, side_r.tex_u, depth_r,
                      sy_r, sx_r, inv_r, side_r.visible, side_r.clip_w,
                      side_r.clip_z[47:0], side_r.clip_y[47:0],
                      side_r.clip_x[47:0]};

endmodule

// ===== sv/fvt_div.sv =====
// fvt_div: pipelined restoring divider giving 2^(2*FRAC_BITS) / w, one quotient
// bit per stage, with sign restore and zero for w of zero. Depends on fvt_pkg.
module fvt_div
  import fvt_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_mag,
  input  logic        in_neg,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [63:0] out_inv,
  output side_t       out_side
);

  localparam int QB = 2 * FRAC_BITS + 1;

  logic [QB-1:0] v_r;
  logic [QB-1:0] neg_r;
  logic [63:0]   rem_r  [QB];
  logic [QB-1:0] quo_r  [QB];
  logic [63:0]   mag_r  [QB];
  side_t         side_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic          v_in;
    logic          neg_in;
    logic [63:0]   rem_in;
    logic [QB-1:0] quo_in;
    logic [63:0]   mag_in;
    side_t         side_in;
    logic [64:0]   trial;
    logic [64:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign neg_in  = in_neg;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign mag_in  = in_mag;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign neg_in  = neg_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign mag_in  = mag_r[k-1];
      assign side_in = side_r[k-1];
    end

    // the numerator has a single set bit, the top one
    assign trial = {rem_in, 1'(k == 0)};
    assign diff  = trial - {1'b0, mag_in};
    assign ge    = (trial >= {1'b0, mag_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[63:0] : trial[63:0];
        quo_r[k]  <= {quo_in[QB-2:0], ge};
        mag_r[k]  <= mag_in;
        neg_r[k]  <= neg_in;
        side_r[k] <= side_in;
      end
    end
  end

  logic [63:0] quo_ext;

  assign quo_ext   = {{(64-QB){1'b0}}, quo_r[QB-1]};
  assign out_valid = v_r[QB-1];
  assign out_side  = side_r[QB-1];
  assign out_inv   = (mag_r[QB-1] == 64'd0) ? 64'd0 :
                     neg_r[QB-1] ? (64'd0 - quo_ext) : quo_ext;

endmodule
